// ----- hw/rtl/pthc_pkg.sv -----
// Shared types, codes and micro-op encoding for the compensation unit.
`default_nettype none
package pthc_pkg;

  typedef enum logic [1:0] {
    OP_TEMP  = 2'd0,
    OP_PRESS = 2'd1,
    OP_HUMID = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  localparam logic [2:0] REG_TEMP   = 3'd0;
  localparam logic [2:0] REG_PLOW   = 3'd1;
  localparam logic [2:0] REG_PHIGH  = 3'd2;
  localparam logic [2:0] REG_PNINE  = 3'd3;
  localparam logic [2:0] REG_HUMID  = 3'd4;

  // Rounded-up reciprocal of ten scaled by 2^35; exact for every 32-bit dividend.
  localparam logic [31:0] Recip10 = 32'hCCCC_CCCD;

  // Operand selectors for the shared ALU.
  typedef enum logic [4:0] {
    SRC_ACC  = 5'd0,
    SRC_R0   = 5'd1,
    SRC_R1   = 5'd2,
    SRC_R2   = 5'd3,
    SRC_R3   = 5'd4,
    SRC_ADC  = 5'd5,
    SRC_FINE = 5'd6,
    SRC_T1   = 5'd7,
    SRC_T2   = 5'd8,
    SRC_T3   = 5'd9,
    SRC_P1   = 5'd10,
    SRC_P2   = 5'd11,
    SRC_P3   = 5'd12,
    SRC_P4   = 5'd13,
    SRC_P5   = 5'd14,
    SRC_P6   = 5'd15,
    SRC_P7   = 5'd16,
    SRC_P8   = 5'd17,
    SRC_P9   = 5'd18,
    SRC_H1   = 5'd19,
    SRC_H2   = 5'd20,
    SRC_H3   = 5'd21,
    SRC_H4   = 5'd22,
    SRC_H5   = 5'd23,
    SRC_H6   = 5'd24,
    SRC_IMM  = 5'd25
  } src_e;

  // ALU functions. Shift amount comes from the immediate.
  typedef enum logic [3:0] {
    FN_ADD  = 4'd0,
    FN_SUB  = 4'd1,
    FN_MUL  = 4'd2,
    FN_SRA  = 4'd3,
    FN_SRL  = 4'd4,
    FN_SLL  = 4'd5,
    FN_CLMP = 4'd6,
    FN_DIV  = 4'd7,
    FN_MOVA = 4'd8,
    FN_DV10 = 4'd9
  } fn_e;

  typedef enum logic [2:0] {
    DST_ACC  = 3'd0,
    DST_R0   = 3'd1,
    DST_R1   = 3'd2,
    DST_R2   = 3'd3,
    DST_R3   = 3'd4,
    DST_FINE = 3'd5
  } dst_e;

  // One micro-op: dst = a fn b.
  typedef struct packed {
    fn_e         fn;
    src_e        a;
    src_e        b;
    dst_e        dst;
    logic [31:0] imm;
  } uop_t;

  // Controller to datapath.
  typedef struct packed {
    logic  load;      // capture the input beat
    logic  exec;      // run the micro-op this cycle
    logic  div_start; // launch the divider
    logic  zchk;      // latch divisor-zero test on r0
    uop_t  uop;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic div_busy;
    logic div_zero;
  } dp_sts_t;

  localparam int unsigned ProgLen = 64;
  localparam int unsigned PcW = 6;

  function automatic uop_t mk(fn_e f, src_e a, src_e b, dst_e d, logic [31:0] i);
    uop_t u;
    u.fn = f; u.a = a; u.b = b; u.dst = d; u.imm = i;
    return u;
  endfunction

  // Temperature program starts at 0.
  localparam logic [PcW-1:0] PC_TEMP = 6'd0;
  localparam logic [PcW-1:0] PC_TEND = 6'd14;
  // Pressure program, phase one ends with divisor in r0.
  localparam logic [PcW-1:0] PC_PRESS = 6'd0;
  localparam logic [PcW-1:0] PC_PDIV  = 6'd21;
  localparam logic [PcW-1:0] PC_PEND  = 6'd39;

  // Temperature micro-program.
  function automatic uop_t temp_rom(logic [PcW-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = mk(FN_SRA, SRC_ADC, SRC_IMM, DST_R0, 32'd3);
      6'd1:  u = mk(FN_SLL, SRC_T1, SRC_IMM, DST_R1, 32'd1);
      6'd2:  u = mk(FN_SUB, SRC_R0, SRC_R1, DST_R0, 32'd0);
      6'd3:  u = mk(FN_MUL, SRC_R0, SRC_T2, DST_R0, 32'd0);
      6'd4:  u = mk(FN_SRA, SRC_R0, SRC_IMM, DST_R0, 32'd11);
      6'd5:  u = mk(FN_SRA, SRC_ADC, SRC_IMM, DST_R1, 32'd4);
      6'd6:  u = mk(FN_SUB, SRC_R1, SRC_T1, DST_R1, 32'd0);
      6'd7:  u = mk(FN_MUL, SRC_R1, SRC_R1, DST_R1, 32'd0);
      6'd8:  u = mk(FN_SRA, SRC_R1, SRC_IMM, DST_R1, 32'd12);
      6'd9:  u = mk(FN_MUL, SRC_R1, SRC_T3, DST_R1, 32'd0);
      6'd10: u = mk(FN_SRA, SRC_R1, SRC_IMM, DST_R1, 32'd14);
      6'd11: u = mk(FN_ADD, SRC_R0, SRC_R1, DST_FINE, 32'd0);
      6'd12: u = mk(FN_MUL, SRC_FINE, SRC_IMM, DST_ACC, 32'd5);
      6'd13: u = mk(FN_ADD, SRC_ACC, SRC_IMM, DST_ACC, 32'd128);
      6'd14: u = mk(FN_SRA, SRC_ACC, SRC_IMM, DST_ACC, 32'd8);
      default: u = mk(FN_MOVA, SRC_ACC, SRC_ACC, DST_ACC, 32'd0);
    endcase
    return u;
  endfunction

  // Pressure micro-program. Step 26 is the divide itself.
  function automatic uop_t press_rom(logic [PcW-1:0] pc);
    uop_t u;
    case (pc)
      // r0 = v1, r1 = sq
      6'd0:  u = mk(FN_SRA, SRC_FINE, SRC_IMM, DST_R0, 32'd1);
      6'd1:  u = mk(FN_SUB, SRC_R0, SRC_IMM, DST_R0, 32'd64000);
      6'd2:  u = mk(FN_SRA, SRC_R0, SRC_IMM, DST_R1, 32'd2);
      6'd3:  u = mk(FN_MUL, SRC_R1, SRC_R1, DST_R1, 32'd0);
      // r2 = v2
      6'd4:  u = mk(FN_SRA, SRC_R1, SRC_IMM, DST_R2, 32'd11);
      6'd5:  u = mk(FN_MUL, SRC_R2, SRC_P6, DST_R2, 32'd0);
      6'd6:  u = mk(FN_MUL, SRC_R0, SRC_P5, DST_ACC, 32'd0);
      6'd7:  u = mk(FN_SLL, SRC_ACC, SRC_IMM, DST_ACC, 32'd1);
      6'd8:  u = mk(FN_ADD, SRC_R2, SRC_ACC, DST_R2, 32'd0);
      6'd9:  u = mk(FN_SRA, SRC_R2, SRC_IMM, DST_R2, 32'd2);
      6'd10: u = mk(FN_SLL, SRC_P4, SRC_IMM, DST_ACC, 32'd16);
      6'd11: u = mk(FN_ADD, SRC_R2, SRC_ACC, DST_R2, 32'd0);
      // new v1 into r0
      6'd12: u = mk(FN_SRA, SRC_R1, SRC_IMM, DST_R1, 32'd13);
      6'd13: u = mk(FN_MUL, SRC_P3, SRC_R1, DST_R1, 32'd0);
      6'd14: u = mk(FN_SRA, SRC_R1, SRC_IMM, DST_R1, 32'd3);
      6'd15: u = mk(FN_MUL, SRC_P2, SRC_R0, DST_R0, 32'd0);
      6'd16: u = mk(FN_SRA, SRC_R0, SRC_IMM, DST_R0, 32'd1);
      6'd17: u = mk(FN_ADD, SRC_R1, SRC_R0, DST_R0, 32'd0);
      6'd18: u = mk(FN_SRA, SRC_R0, SRC_IMM, DST_R0, 32'd18);
      6'd19: u = mk(FN_ADD, SRC_R0, SRC_IMM, DST_R0, 32'd32768);
      6'd20: u = mk(FN_MUL, SRC_R0, SRC_P1, DST_R0, 32'd0);
      6'd21: u = mk(FN_SRA, SRC_R0, SRC_IMM, DST_R0, 32'd15);
      // acc = p numerator: (1048576 - adc - (v2>>12)) * 3125
      6'd22: u = mk(FN_SUB, SRC_IMM, SRC_ADC, DST_ACC, 32'd1048576);
      6'd23: u = mk(FN_SRA, SRC_R2, SRC_IMM, DST_R2, 32'd12);
      6'd24: u = mk(FN_SUB, SRC_ACC, SRC_R2, DST_ACC, 32'd0);
      6'd25: u = mk(FN_MUL, SRC_ACC, SRC_IMM, DST_ACC, 32'd3125);
      6'd26: u = mk(FN_DIV, SRC_ACC, SRC_R0, DST_ACC, 32'd0);
      // post-divide correction, p in acc
      6'd27: u = mk(FN_SRL, SRC_ACC, SRC_IMM, DST_R0, 32'd3);
      6'd28: u = mk(FN_MUL, SRC_R0, SRC_R0, DST_R0, 32'd0);
      6'd29: u = mk(FN_SRL, SRC_R0, SRC_IMM, DST_R0, 32'd13);
      6'd30: u = mk(FN_MUL, SRC_P9, SRC_R0, DST_R0, 32'd0);
      6'd31: u = mk(FN_SRA, SRC_R0, SRC_IMM, DST_R0, 32'd12);
      6'd32: u = mk(FN_SRL, SRC_ACC, SRC_IMM, DST_R1, 32'd2);
      6'd33: u = mk(FN_MUL, SRC_R1, SRC_P8, DST_R1, 32'd0);
      6'd34: u = mk(FN_SRA, SRC_R1, SRC_IMM, DST_R1, 32'd13);
      6'd35: u = mk(FN_ADD, SRC_R0, SRC_R1, DST_R0, 32'd0);
      6'd36: u = mk(FN_ADD, SRC_R0, SRC_P7, DST_R0, 32'd0);
      6'd37: u = mk(FN_SRA, SRC_R0, SRC_IMM, DST_R0, 32'd4);
      6'd38: u = mk(FN_ADD, SRC_ACC, SRC_R0, DST_ACC, 32'd0);
      6'd39: u = mk(FN_DV10, SRC_ACC, SRC_ACC, DST_ACC, 32'd0);
      default: u = mk(FN_MOVA, SRC_ACC, SRC_ACC, DST_ACC, 32'd0);
    endcase
    return u;
  endfunction

  // Humidity micro-program.
  function automatic uop_t humid_rom(logic [PcW-1:0] pc);
    uop_t u;
    case (pc)
      // r3 = v = fine - 76800
      6'd0:  u = mk(FN_SUB, SRC_FINE, SRC_IMM, DST_R3, 32'd76800);
      // r0 = x
      6'd1:  u = mk(FN_SLL, SRC_ADC, SRC_IMM, DST_R0, 32'd14);
      6'd2:  u = mk(FN_SLL, SRC_H4, SRC_IMM, DST_ACC, 32'd20);
      6'd3:  u = mk(FN_SUB, SRC_R0, SRC_ACC, DST_R0, 32'd0);
      6'd4:  u = mk(FN_MUL, SRC_H5, SRC_R3, DST_ACC, 32'd0);
      6'd5:  u = mk(FN_SUB, SRC_R0, SRC_ACC, DST_R0, 32'd0);
      6'd6:  u = mk(FN_ADD, SRC_R0, SRC_IMM, DST_R0, 32'd16384);
      6'd7:  u = mk(FN_SRA, SRC_R0, SRC_IMM, DST_R0, 32'd15);
      // r1 = y, r2 = z
      6'd8:  u = mk(FN_MUL, SRC_R3, SRC_H6, DST_R1, 32'd0);
      6'd9:  u = mk(FN_SRA, SRC_R1, SRC_IMM, DST_R1, 32'd10);
      6'd10: u = mk(FN_MUL, SRC_R3, SRC_H3, DST_R2, 32'd0);
      6'd11: u = mk(FN_SRA, SRC_R2, SRC_IMM, DST_R2, 32'd11);
      6'd12: u = mk(FN_ADD, SRC_R2, SRC_IMM, DST_R2, 32'd32768);
      6'd13: u = mk(FN_MUL, SRC_R1, SRC_R2, DST_R1, 32'd0);
      6'd14: u = mk(FN_SRA, SRC_R1, SRC_IMM, DST_R1, 32'd10);
      6'd15: u = mk(FN_ADD, SRC_R1, SRC_IMM, DST_R1, 32'd2097152);
      6'd16: u = mk(FN_MUL, SRC_R1, SRC_H2, DST_R1, 32'd0);
      6'd17: u = mk(FN_ADD, SRC_R1, SRC_IMM, DST_R1, 32'd8192);
      6'd18: u = mk(FN_SRA, SRC_R1, SRC_IMM, DST_R1, 32'd14);
      // r3 = v = x*y, r2 = s
      6'd19: u = mk(FN_MUL, SRC_R0, SRC_R1, DST_R3, 32'd0);
      6'd20: u = mk(FN_SRA, SRC_R3, SRC_IMM, DST_R2, 32'd15);
      6'd21: u = mk(FN_MUL, SRC_R2, SRC_R2, DST_R2, 32'd0);
      6'd22: u = mk(FN_SRA, SRC_R2, SRC_IMM, DST_R2, 32'd7);
      6'd23: u = mk(FN_MUL, SRC_R2, SRC_H1, DST_R2, 32'd0);
      6'd24: u = mk(FN_SRA, SRC_R2, SRC_IMM, DST_R2, 32'd4);
      6'd25: u = mk(FN_SUB, SRC_R3, SRC_R2, DST_ACC, 32'd0);
      6'd26: u = mk(FN_CLMP, SRC_ACC, SRC_IMM, DST_ACC, 32'd419430400);
      6'd27: u = mk(FN_SRL, SRC_ACC, SRC_IMM, DST_ACC, 32'd12);
      6'd28: u = mk(FN_MUL, SRC_ACC, SRC_IMM, DST_ACC, 32'd125);
      6'd29: u = mk(FN_SRL, SRC_ACC, SRC_IMM, DST_ACC, 32'd7);
      default: u = mk(FN_MOVA, SRC_ACC, SRC_ACC, DST_ACC, 32'd0);
    endcase
    return u;
  endfunction

  localparam logic [PcW-1:0] PC_HEND = 6'd29;
  localparam logic [PcW-1:0] PC_PZCHK = 6'd22;

endpackage
`default_nettype wire

// ----- hw/rtl/pthc_divider.sv -----
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
`default_nettype none
module pthc_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             busy_o,
  output logic [31:0]      quotient_o
);

  logic [31:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] trial;

  // One shift-subtract step per cycle.
  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = 6'd32;
    end else if (cnt_q != 6'd0) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = (cnt_q != 6'd0);
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// ----- hw/rtl/pthc_datapath.sv -----
// Register file, shared ALU and divider for the compensation sequences.
`default_nettype none
module pthc_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pthc_pkg::dp_cmd_t cmd_i,
  output pthc_pkg::dp_sts_t      sts_o,
  input  wire logic [19:0]       raw_i,
  input  wire logic              humid_i,
  input  wire logic [47:0]       temp_coeffs_i,
  input  wire logic [63:0]       plow_i,
  input  wire logic [63:0]       phigh_i,
  input  wire logic [15:0]       pnine_i,
  input  wire logic [63:0]       hcoef_i,
  output logic [31:0]            acc_o
);

  logic [31:0] acc_q, r0_q, r1_q, r2_q, r3_q, fine_q, adc_q;
  logic [31:0] res;
  logic [31:0] opa, opb;
  logic        dz_q;
  logic [31:0] div_q;
  logic        div_busy;
  logic [31:0] div_num;
  logic [31:0] shl1;
  logic [63:0] prod10;

  function automatic logic [31:0] pick(pthc_pkg::src_e s, logic [31:0] acc, logic [31:0] r0,
      logic [31:0] r1, logic [31:0] r2, logic [31:0] r3, logic [31:0] adc, logic [31:0] fine,
      logic [31:0] imm, logic [47:0] tc, logic [63:0] pl, logic [63:0] ph, logic [15:0] p9,
      logic [63:0] hc);
    logic [31:0] v;
    case (s)
      pthc_pkg::SRC_ACC:  v = acc;
      pthc_pkg::SRC_R0:   v = r0;
      pthc_pkg::SRC_R1:   v = r1;
      pthc_pkg::SRC_R2:   v = r2;
      pthc_pkg::SRC_R3:   v = r3;
      pthc_pkg::SRC_ADC:  v = adc;
      pthc_pkg::SRC_FINE: v = fine;
      pthc_pkg::SRC_T1:   v = {16'd0, tc[15:0]};
      pthc_pkg::SRC_T2:   v = {{16{tc[31]}}, tc[31:16]};
      pthc_pkg::SRC_T3:   v = {{16{tc[47]}}, tc[47:32]};
      pthc_pkg::SRC_P1:   v = {16'd0, pl[15:0]};
      pthc_pkg::SRC_P2:   v = {{16{pl[31]}}, pl[31:16]};
      pthc_pkg::SRC_P3:   v = {{16{pl[47]}}, pl[47:32]};
      pthc_pkg::SRC_P4:   v = {{16{pl[63]}}, pl[63:48]};
      pthc_pkg::SRC_P5:   v = {{16{ph[15]}}, ph[15:0]};
      pthc_pkg::SRC_P6:   v = {{16{ph[31]}}, ph[31:16]};
      pthc_pkg::SRC_P7:   v = {{16{ph[47]}}, ph[47:32]};
      pthc_pkg::SRC_P8:   v = {{16{ph[63]}}, ph[63:48]};
      pthc_pkg::SRC_P9:   v = {{16{p9[15]}}, p9};
      pthc_pkg::SRC_H1:   v = {24'd0, hc[7:0]};
      pthc_pkg::SRC_H2:   v = {{16{hc[23]}}, hc[23:8]};
      pthc_pkg::SRC_H3:   v = {24'd0, hc[31:24]};
      pthc_pkg::SRC_H4:   v = {{20{hc[43]}}, hc[43:32]};
      pthc_pkg::SRC_H5:   v = {{20{hc[55]}}, hc[55:44]};
      pthc_pkg::SRC_H6:   v = {{24{hc[63]}}, hc[63:56]};
      pthc_pkg::SRC_IMM:  v = imm;
      default:            v = '0;
    endcase
    return v;
  endfunction

  // Operand selection.
  always_comb begin
    opa = pick(cmd_i.uop.a, acc_q, r0_q, r1_q, r2_q, r3_q, adc_q, fine_q, cmd_i.uop.imm,
               temp_coeffs_i, plow_i, phigh_i, pnine_i, hcoef_i);
    opb = pick(cmd_i.uop.b, acc_q, r0_q, r1_q, r2_q, r3_q, adc_q, fine_q, cmd_i.uop.imm,
               temp_coeffs_i, plow_i, phigh_i, pnine_i, hcoef_i);
  end

  // The divide takes (p<<1)/v1 when p is below 2^31, else p/v1 then doubled.
  assign div_num = opa[31] ? opa : {opa[30:0], 1'b0};
  assign shl1    = {div_q[30:0], 1'b0};

  // Division by ten as a multiplication by the scaled reciprocal.
  assign prod10 = {32'd0, opa} * {32'd0, pthc_pkg::Recip10};

  pthc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_num),
    .divisor_i  (opb),
    .busy_o     (div_busy),
    .quotient_o (div_q)
  );

  logic big_q;

  // Shared ALU.
  always_comb begin
    case (cmd_i.uop.fn)
      pthc_pkg::FN_ADD:  res = opa + opb;
      pthc_pkg::FN_SUB:  res = opa - opb;
      pthc_pkg::FN_MUL:  res = 32'(opa * opb);
      pthc_pkg::FN_SRA:  res = 32'($signed(opa) >>> opb[4:0]);
      pthc_pkg::FN_SRL:  res = opa >> opb[4:0];
      pthc_pkg::FN_SLL:  res = opa << opb[4:0];
      pthc_pkg::FN_CLMP: res = opa[31] ? 32'd0 : ((opa > opb) ? opb : opa);
      pthc_pkg::FN_DIV:  res = big_q ? shl1 : div_q;
      pthc_pkg::FN_MOVA: res = opa;
      pthc_pkg::FN_DV10: res = {3'd0, prod10[63:35]};
      default:           res = opa;
    endcase
  end

  // Result write-back and input capture.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fine_q <= '0;
      dz_q   <= 1'b0;
      big_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        dz_q <= 1'b0;
      end
      if (cmd_i.zchk) begin
        dz_q <= (r0_q == 32'd0);
      end
      if (cmd_i.div_start) begin
        big_q <= opa[31];
      end
      if (cmd_i.exec && cmd_i.uop.dst == pthc_pkg::DST_FINE) begin
        fine_q <= res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      adc_q <= humid_i ? {16'd0, raw_i[15:0]} : {12'd0, raw_i};
      acc_q <= '0;
    end else if (cmd_i.exec) begin
      case (cmd_i.uop.dst)
        pthc_pkg::DST_ACC: acc_q <= res;
        pthc_pkg::DST_R0:  r0_q  <= res;
        pthc_pkg::DST_R1:  r1_q  <= res;
        pthc_pkg::DST_R2:  r2_q  <= res;
        pthc_pkg::DST_R3:  r3_q  <= res;
        default:           acc_q <= acc_q;
      endcase
    end
  end

  assign sts_o.div_busy = div_busy;
  assign sts_o.div_zero = dz_q;
  assign acc_o          = acc_q;

endmodule
`default_nettype wire

// ----- hw/rtl/pthc_ctrl.sv -----
// Sequencer that steps through the micro-program for each operation.
`default_nettype none
module pthc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        op_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output logic                   res_zero_o,
  output logic                   res_clear_o,
  output pthc_pkg::dp_cmd_t      cmd_o,
  input  wire pthc_pkg::dp_sts_t sts_i,
  output logic                   humid_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RUN  = 3'd1;
  localparam logic [2:0] S_DIVS = 3'd2;
  localparam logic [2:0] S_DIVW = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_q, state_d;
  logic [pthc_pkg::PcW-1:0] pc_q, pc_d;
  logic [1:0] op_q, op_d;
  logic       vld_q, vld_d;
  logic       zero_q, zero_d;
  logic       clr_q, clr_d;
  pthc_pkg::uop_t uop;
  logic       last;
  logic       accept;

  assign accept = in_valid_i && in_ready_o;

  // Program store lookup.
  always_comb begin
    case (op_q)
      pthc_pkg::OP_TEMP: begin
        uop  = pthc_pkg::temp_rom(pc_q);
        last = (pc_q == pthc_pkg::PC_TEND);
      end
      pthc_pkg::OP_PRESS: begin
        uop  = pthc_pkg::press_rom(pc_q);
        last = (pc_q == pthc_pkg::PC_PEND);
      end
      pthc_pkg::OP_HUMID: begin
        uop  = pthc_pkg::humid_rom(pc_q);
        last = (pc_q == pthc_pkg::PC_HEND);
      end
      default: begin
        uop  = pthc_pkg::temp_rom(pc_q);
        last = 1'b1;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    op_d    = op_q;
    vld_d   = vld_q;
    zero_d  = zero_q;
    clr_d   = clr_q;
    cmd_o.load      = 1'b0;
    cmd_o.exec      = 1'b0;
    cmd_o.div_start = 1'b0;
    cmd_o.zchk      = 1'b0;
    cmd_o.uop       = uop;
    if (vld_q && res_ready_i) begin
      vld_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          op_d       = op_i;
          pc_d       = '0;
          state_d    = (op_i == pthc_pkg::OP_NONE) ? S_DONE : S_RUN;
        end
      end
      S_RUN: begin
        if (uop.fn == pthc_pkg::FN_DIV) begin
          if (op_q == pthc_pkg::OP_PRESS && pc_q != pthc_pkg::PC_PEND && sts_i.div_zero) begin
            state_d = S_DONE;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIVS;
          end
        end else begin
          cmd_o.exec = 1'b1;
          cmd_o.zchk = (op_q == pthc_pkg::OP_PRESS) && (pc_q == pthc_pkg::PC_PZCHK);
          pc_d       = pc_q + 1'b1;
          if (last) begin
            state_d = S_DONE;
          end
        end
      end
      S_DIVS: begin
        state_d = S_DIVW;
      end
      S_DIVW: begin
        if (!sts_i.div_busy) begin
          cmd_o.exec = 1'b1;
          pc_d       = pc_q + 1'b1;
          state_d    = last ? S_DONE : S_RUN;
        end
      end
      S_DONE: begin
        if (!vld_q || res_ready_i) begin
          vld_d   = 1'b1;
          zero_d  = (op_q == pthc_pkg::OP_PRESS) && sts_i.div_zero;
          clr_d   = (op_q == pthc_pkg::OP_NONE) || zero_d;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      op_q    <= pthc_pkg::OP_TEMP;
      vld_q   <= 1'b0;
      zero_q  <= 1'b0;
      clr_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      op_q    <= op_d;
      vld_q   <= vld_d;
      zero_q  <= zero_d;
      clr_q   <= clr_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = vld_q;
  assign res_zero_o  = zero_q;
  assign res_clear_o = clr_q;
  assign humid_o     = (op_i == pthc_pkg::OP_HUMID);

endmodule
`default_nettype wire

// ----- hw/rtl/pth_sensor_compensation_top.sv -----
// Top level of the pressure, temperature and humidity compensation unit.
//
//  channel | direction | beat contents
//  in      | sink      | operation_i, raw_reading_i
//  out     | source    | compensated_o, divisor_zero_o
//  cfg     | sink      | cfg_index_i, cfg_data_i
//
// One input beat is taken at a time. The time from acceptance to the next ready depends
// on the operation, and pressure is shorter when the divisor is zero; it is set by
// the single shared ALU stepping the micro-program and the bit-serial divider.
// Reset clears fine temperature and coefficients to zero. A result beat is
// held in an output register; the next input is taken once it is registered.
`default_nettype none
module pth_sensor_compensation_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [19:0] raw_reading_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      compensated_o,
  output logic             divisor_zero_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  logic [47:0] temp_q;
  logic [63:0] plow_q, phigh_q, hcoef_q;
  logic [15:0] pnine_q;
  pthc_pkg::dp_cmd_t cmd;
  pthc_pkg::dp_sts_t sts;
  logic [31:0] acc;
  logic [31:0] res_q;
  logic        vld;
  logic        zero;
  logic        clr;
  logic        humid;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q  <= '0;
      plow_q  <= '0;
      phigh_q <= '0;
      pnine_q <= '0;
      hcoef_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pthc_pkg::REG_TEMP:  temp_q  <= cfg_data_i[47:0];
        pthc_pkg::REG_PLOW:  plow_q  <= cfg_data_i;
        pthc_pkg::REG_PHIGH: phigh_q <= cfg_data_i;
        pthc_pkg::REG_PNINE: pnine_q <= cfg_data_i[15:0];
        pthc_pkg::REG_HUMID: hcoef_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pthc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (operation_i),
    .res_valid_o (vld),
    .res_ready_i (out_ready_i),
    .res_zero_o  (zero),
    .res_clear_o (clr),
    .cmd_o       (cmd),
    .sts_i       (sts),
    .humid_o     (humid)
  );

  pthc_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .raw_i         (raw_reading_i),
    .humid_i       (humid),
    .temp_coeffs_i (temp_q),
    .plow_i        (plow_q),
    .phigh_i       (phigh_q),
    .pnine_i       (pnine_q),
    .hcoef_i       (hcoef_q),
    .acc_o         (acc)
  );

  // Output register, holding the finished result while the next sequence runs.
  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      res_q <= acc;
    end
  end

  assign out_valid_o    = vld;
  assign compensated_o  = clr ? 32'd0 : (in_ready_o ? acc : res_q);
  assign divisor_zero_o = zero;

  // Nothing is taken in while a sequence runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken during a running sequence");

  // A flagged pressure result reads as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && divisor_zero_o) |-> (compensated_o == 32'd0))
    else $error("divisor-zero result not cleared");

  // A waiting result keeps its value until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(compensated_o))
    else $error("result changed while stalled");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the pressure, temperature and humidity compensation unit.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    pthc_pkg::op_e op;
    logic [19:0]   raw;
  } reading_t;

  typedef struct packed {
    logic [31:0] value;
    logic        dzero;
  } comp_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  operation;
  logic [19:0] raw_reading;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] compensated;
  logic        divisor_zero;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  pth_sensor_compensation_top u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .operation_i    (operation),
    .raw_reading_i  (raw_reading),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .compensated_o  (compensated),
    .divisor_zero_o (divisor_zero),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // Predictor state: calibration copies and the fine temperature.
  logic [47:0] cal_temp;
  logic [63:0] cal_plow;
  logic [63:0] cal_phigh;
  logic [15:0] cal_p9;
  logic [63:0] cal_humid;
  logic [31:0] fine_t;

  reading_t pending_readings[$];
  comp_t    expected_comps[$];
  int       errors;
  int       n_checked;
  int       n_dzero;
  int       idle_cycles;
  logic     hold_off;
  logic     sender_pause;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] asr(logic [31:0] a, int n);
    return $unsigned($signed(a) >>> n);
  endfunction

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx12(logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

  // Temperature compensation; updates the fine temperature.
  function automatic logic [31:0] comp_temperature(logic [31:0] adc);
    logic [31:0] t1, t2, t3, a, d, b;
    t1 = {16'd0, cal_temp[15:0]};
    t2 = sx16(cal_temp[31:16]);
    t3 = sx16(cal_temp[47:32]);
    a = asr((asr(adc, 3) - (t1 << 1)) * t2, 11);
    d = asr(adc, 4) - t1;
    b = asr(asr(d * d, 12) * t3, 14);
    fine_t = a + b;
    return asr(fine_t * 32'd5 + 32'd128, 8);
  endfunction

  // Pressure compensation; flags a zero divisor.
  function automatic logic [31:0] comp_pressure(logic [31:0] adc, output logic dz);
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] v1, q, sq, v2, p, u, w1, w2;
    p1 = {16'd0, cal_plow[15:0]};
    p2 = sx16(cal_plow[31:16]);
    p3 = sx16(cal_plow[47:32]);
    p4 = sx16(cal_plow[63:48]);
    p5 = sx16(cal_phigh[15:0]);
    p6 = sx16(cal_phigh[31:16]);
    p7 = sx16(cal_phigh[47:32]);
    p8 = sx16(cal_phigh[63:48]);
    p9 = sx16(cal_p9);
    dz = 1'b0;
    v1 = asr(fine_t, 1) - 32'd64000;
    q = asr(v1, 2);
    sq = q * q;
    v2 = asr(sq, 11) * p6;
    v2 = v2 + ((v1 * p5) << 1);
    v2 = asr(v2, 2) + (p4 << 16);
    v1 = asr(asr(p3 * asr(sq, 13), 3) + asr(p2 * v1, 1), 18);
    v1 = asr((32'd32768 + v1) * p1, 15);
    if (v1 == 32'd0) begin
      dz = 1'b1;
      return 32'd0;
    end
    p = ((32'd1048576 - adc) - asr(v2, 12)) * 32'd3125;
    if (p < 32'h8000_0000) p = (p << 1) / v1;
    else p = (p / v1) * 32'd2;
    u = ((p >> 3) * (p >> 3)) >> 13;
    w1 = asr(p9 * u, 12);
    w2 = asr((p >> 2) * p8, 13);
    p = p + asr(w1 + w2 + p7, 4);
    return p / 32'd10;
  endfunction

  // Humidity compensation with clamping of the intermediate.
  function automatic logic [31:0] comp_humidity(logic [31:0] adc);
    logic [31:0] h1, h2, h3, h4, h5, h6, v, x, y, z, s;
    h1 = {24'd0, cal_humid[7:0]};
    h2 = sx16(cal_humid[23:8]);
    h3 = {24'd0, cal_humid[31:24]};
    h4 = sx12(cal_humid[43:32]);
    h5 = sx12(cal_humid[55:44]);
    h6 = {{24{cal_humid[63]}}, cal_humid[63:56]};
    v = fine_t - 32'd76800;
    x = asr((adc << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
    y = asr(v * h6, 10);
    z = asr(v * h3, 11) + 32'd32768;
    y = asr(y * z, 10) + 32'd2097152;
    y = asr(y * h2 + 32'd8192, 14);
    v = x * y;
    s = asr(v, 15);
    v = v - asr(asr(s * s, 7) * h1, 4);
    if (v[31]) v = 32'd0;
    else if (v > 32'd419430400) v = 32'd419430400;
    return ((v >> 12) * 32'd125) >> 7;
  endfunction

  function automatic comp_t predict_reading(reading_t r);
    comp_t c;
    c.value = 32'd0;
    c.dzero = 1'b0;
    case (r.op)
      pthc_pkg::OP_TEMP:  c.value = comp_temperature({12'd0, r.raw});
      pthc_pkg::OP_PRESS: c.value = comp_pressure({12'd0, r.raw}, c.dzero);
      pthc_pkg::OP_HUMID: c.value = comp_humidity({16'd0, r.raw[15:0]});
      default:            c.value = 32'd0;
    endcase
    return c;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
    return $urandom_range(1, 4);
  endfunction

  // Input driver: offers queued readings with random gaps.
  int in_gap;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid    <= 1'b0;
      operation   <= 2'd0;
      raw_reading <= 20'd0;
      in_gap      <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_comps.push_back(predict_reading(reading_t'({operation, raw_reading})));
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_readings.size() > 0 && !sender_pause) begin
          reading_t r;
          r = pending_readings.pop_front();
          operation   <= r.op;
          raw_reading <= r.raw;
          in_valid    <= 1'b1;
          in_gap      <= gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random back-pressure and a field-by-field compare.
  int out_gap;
  int hold_count;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      out_gap    <= 0;
      hold_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        comp_t e;
        if (expected_comps.size() == 0) begin
          $display("%0t: unexpected result beat %h dz %b", $time, compensated, divisor_zero);
          errors++;
        end else begin
          e = expected_comps.pop_front();
          n_checked++;
          if (e.dzero) n_dzero++;
          if (compensated !== e.value) begin
            $display("%0t: compensated mismatch: expected %h, actual %h",
                     $time, e.value, compensated);
            errors++;
          end
          if (divisor_zero !== e.dzero) begin
            $display("%0t: divisor_zero mismatch: expected %b, actual %b",
                     $time, e.dzero, divisor_zero);
            errors++;
          end
        end
      end
      if (hold_off) begin
        out_ready  <= 1'b0;
        hold_count <= hold_count + 1;
      end else if (out_gap > 0) begin
        out_gap   <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready) out_gap <= gap_len();
      end
    end
  end

  // Watchdog on cycles with no beat accepted on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || hold_off || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      pthc_pkg::REG_TEMP:  cal_temp  = data[47:0];
      pthc_pkg::REG_PLOW:  cal_plow  = data;
      pthc_pkg::REG_PHIGH: cal_phigh = data;
      pthc_pkg::REG_PNINE: cal_p9    = data[15:0];
      pthc_pkg::REG_HUMID: cal_humid = data;
      default: ;
    endcase
  endtask

  // Waits for the block to drain, then a margin for any work in flight.
  task automatic drain();
    while (pending_readings.size() > 0 || in_valid || expected_comps.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic queue_reading(pthc_pkg::op_e op, logic [19:0] raw);
    reading_t r;
    r.op  = op;
    r.raw = raw;
    pending_readings.push_back(r);
  endtask

  // Realistic calibration set, or a fully random one when random_cal is set.
  task automatic write_calibration(bit random_cal);
    logic [63:0] tc, pl, ph, hc;
    logic [15:0] p9;
    tc = {16'd0, 16'hFC18, 16'd27504} ^ 64'(random_cal ? $urandom_range(0, 15) : 0);
    pl = {16'd2855, 16'hD0C0, 16'd3024, 16'd36477};
    ph = {16'hC255, 16'd15500, 16'hFFF9, 16'd140} ^ (random_cal ? 64'($urandom_range(0, 7)) : 0);
    p9 = 16'd4000;
    hc = {8'd30, 12'd50, 12'd312, 8'd0, 16'd366, 8'd75};
    if (random_cal) begin
      tc = {$urandom, $urandom};
      pl = {$urandom, $urandom};
      ph = {$urandom, $urandom};
      p9 = 16'($urandom);
      hc = {$urandom, $urandom};
    end
    write_reg(pthc_pkg::REG_TEMP, tc);
    write_reg(pthc_pkg::REG_PLOW, pl);
    write_reg(pthc_pkg::REG_PHIGH, ph);
    write_reg(pthc_pkg::REG_PNINE, {48'd0, p9});
    write_reg(pthc_pkg::REG_HUMID, hc);
  endtask

  task automatic queue_random(int count);
    repeat (count) begin
      int k;
      k = $urandom_range(0, 19);
      if (k == 0) queue_reading(pthc_pkg::OP_NONE, 20'($urandom));
      else if (k < 7) queue_reading(pthc_pkg::OP_TEMP, 20'($urandom));
      else if (k < 13) queue_reading(pthc_pkg::OP_PRESS, 20'($urandom));
      else queue_reading(pthc_pkg::OP_HUMID, 20'($urandom));
    end
  endtask

  initial begin
    hold_off     = 1'b0;
    sender_pause = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = 3'd0;
    cfg_data     = 64'd0;
    cal_temp = '0; cal_plow = '0; cal_phigh = '0; cal_p9 = '0; cal_humid = '0;
    fine_t = '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset calibration: every pressure divisor is zero.
    queue_reading(pthc_pkg::OP_PRESS, 20'hFFFFF);
    queue_reading(pthc_pkg::OP_TEMP, 20'd0);
    queue_reading(pthc_pkg::OP_HUMID, 20'hFFFFF);
    queue_reading(pthc_pkg::OP_NONE, 20'hFFFFF);
    drain();

    // Directed: realistic coefficients, field extremes and every operation.
    write_calibration(1'b0);
    queue_reading(pthc_pkg::OP_TEMP, 20'd519888);
    queue_reading(pthc_pkg::OP_PRESS, 20'd415148);
    queue_reading(pthc_pkg::OP_HUMID, 20'h0FFFF);
    queue_reading(pthc_pkg::OP_HUMID, 20'hF0000);
    queue_reading(pthc_pkg::OP_HUMID, 20'd30000);
    queue_reading(pthc_pkg::OP_TEMP, 20'hFFFFF);
    queue_reading(pthc_pkg::OP_PRESS, 20'd0);
    queue_reading(pthc_pkg::OP_PRESS, 20'hFFFFF);
    queue_reading(pthc_pkg::OP_HUMID, 20'd0);
    queue_reading(pthc_pkg::OP_TEMP, 20'd0);
    queue_reading(pthc_pkg::OP_PRESS, 20'h55555);
    queue_reading(pthc_pkg::OP_HUMID, 20'hAAAAA);
    queue_reading(pthc_pkg::OP_NONE, 20'h12345);
    drain();

    // Extreme coefficient values.
    write_reg(pthc_pkg::REG_TEMP, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(pthc_pkg::REG_PLOW, 64'h8000_8000_8000_FFFF);
    write_reg(pthc_pkg::REG_PHIGH, 64'h7FFF_7FFF_7FFF_7FFF);
    write_reg(pthc_pkg::REG_PNINE, 64'h0000_0000_0000_8000);
    write_reg(pthc_pkg::REG_HUMID, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_reading(pthc_pkg::OP_TEMP, 20'hFFFFF);
    queue_reading(pthc_pkg::OP_PRESS, 20'hFFFFF);
    queue_reading(pthc_pkg::OP_HUMID, 20'hFFFF);
    queue_reading(pthc_pkg::OP_TEMP, 20'd1);
    queue_reading(pthc_pkg::OP_PRESS, 20'd0);
    drain();

    // Random phases with several calibration sets.
    for (int ph = 0; ph < 6; ph++) begin
      write_calibration(ph % 2 == 1);
      queue_random(110);
      if (ph == 2) begin
        // Long receiver hold-off while the sender keeps offering readings.
        hold_off <= 1'b1;
        while (tb_top.u_monitor_hold_done() == 0) @(posedge clk);
        hold_off <= 1'b0;
      end
      if (ph == 3) begin
        // Sender pauses until every expected result has arrived.
        repeat (30) @(posedge clk);
        sender_pause <= 1'b1;
        while (expected_comps.size() > 0 || in_valid) @(posedge clk);
        sender_pause <= 1'b0;
      end
      drain();
    end

    $display("Checked %0d results (%0d with a zero pressure divisor) over reset, realistic,",
             n_checked, n_dzero);
    $display("extreme and random calibration sets, under random stalls on both channels.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // True once the receiver has been held off for a long stretch.
  function automatic bit u_monitor_hold_done();
    return hold_count >= 600;
  endfunction
endmodule
`default_nettype wire

// ----- filelist.f -----
hw/rtl/pthc_pkg.sv
hw/rtl/pthc_divider.sv
hw/rtl/pthc_datapath.sv
hw/rtl/pthc_ctrl.sv
hw/rtl/pth_sensor_compensation_top.sv
tb/tb_top.sv
